>>> rtl/clwm_pkg.sv
// Shared types and constants of the CPU load window monitor.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package clwm_pkg;

    localparam int unsigned PCT_W        = 7;
    localparam int unsigned REF_W        = 24;
    localparam int unsigned WIN_W        = 16;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned CNT_W        = 32;
    localparam int unsigned APB_AW       = 3;
    localparam int unsigned APB_DW       = 32;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned SMOOTH_DEPTH_DEF = 5;

    localparam logic [REF_W-1:0] REF_RESET    = REF_W'(1855000);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);
    localparam logic [PCT_W-1:0] LOAD_FULL    = PCT_W'(100);

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_IDLE0 = 2'd0;
    localparam logic [1:0] OP_IDLE1 = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_REF    = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    typedef struct packed {
        logic [REF_W-1:0] full_idle_reference;
        logic [WIN_W-1:0] window_ms;
    } t_cfg;

    typedef struct packed {
        logic              query;
        logic              core;
        logic [TIME_W-1:0] now_ms;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/clwm_regs.sv
// Configuration registers of the CPU load window monitor behind an APB-style port.
// Depends on clwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clwm_regs import clwm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [REF_W-1:0] r_ref;
    logic [WIN_W-1:0] r_window;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref    <= REF_RESET;
            r_window <= WINDOW_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_REF:    r_ref    <= pwdata[REF_W-1:0];
                REG_WINDOW: r_window <= pwdata[WIN_W-1:0];
                default:    r_ref    <= r_ref;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_REF:    prdata = APB_DW'(r_ref);
            REG_WINDOW: prdata = APB_DW'(r_window);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.full_idle_reference = r_ref;
    assign o_cfg.window_ms           = r_window;

endmodule

`default_nettype wire

>>> rtl/clwm_front.sv
// Input side of the CPU load window monitor: accepts transactions, sorts them
// into idle events and queries, and buffers them in a short queue. Depends on clwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clwm_front import clwm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [1:0]        i_operation,
    input  wire logic [TIME_W-1:0] i_now_ms,
    output logic                   o_item_valid,
    output t_item                  o_item,
    input  wire logic              i_item_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              known_op;
    logic              wr_en;
    logic              rd_en;
    t_item             new_item;

    // Unused operation codes are taken from the port and dropped here.
    assign known_op = (i_operation == OP_IDLE0) || (i_operation == OP_IDLE1)
                   || (i_operation == OP_QUERY);
    assign o_full   = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign wr_en    = i_push && !o_full && known_op;
    assign rd_en    = i_item_pop && (r_fill != '0);

    assign new_item.query  = (i_operation == OP_QUERY);
    assign new_item.core   = (i_operation == OP_IDLE1);
    assign new_item.now_ms = i_now_ms;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_fill <= r_fill + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> rtl/clwm_back.sv
// Execution side of the CPU load window monitor: idle counters, window timing,
// load computation with a shared bit-serial divider, history rings and result register.
// Depends on clwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clwm_back import clwm_pkg::*; #(
    parameter int unsigned SMOOTH_DEPTH = SMOOTH_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_item_valid,
    input  wire t_item      i_item,
    output logic            o_item_pop,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [PCT_W-1:0] o_usage_percent,
    output logic [PCT_W-1:0] o_core0_percent,
    output logic [PCT_W-1:0] o_core1_percent,
    output logic            o_window_closed
);

    localparam int unsigned POS_W   = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
    localparam int unsigned SUM_W   = $clog2(100 * SMOOTH_DEPTH + 1);
    localparam int unsigned DIV_L   = $clog2(SMOOTH_DEPTH);
    localparam int unsigned RCP_S   = SUM_W + DIV_L;
    localparam int unsigned RCP_M_W = RCP_S + 1;
    localparam int unsigned RCP_M   = (2 ** RCP_S + SMOOTH_DEPTH - 1) / SMOOTH_DEPTH;
    localparam int unsigned MP_W    = SUM_W + RCP_M_W;
    localparam int unsigned STEP_W  = $clog2(PCT_W);
    localparam int unsigned PROD_W  = REF_W + PCT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_UPDATE,
        S_MEAN,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt0;
    logic [CNT_W-1:0]    r_cnt1;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   r_now;
    logic [PCT_W-1:0]    r_hist0 [SMOOTH_DEPTH];
    logic [PCT_W-1:0]    r_hist1 [SMOOTH_DEPTH];
    logic [POS_W-1:0]    r_pos;
    logic [SUM_W-1:0]    r_sum0;
    logic [SUM_W-1:0]    r_sum1;
    logic [PCT_W-1:0]    r_smooth0;
    logic [PCT_W-1:0]    r_smooth1;
    logic                r_core;
    logic [PROD_W-1:0]   r_prod;
    logic [CNT_W-1:0]    r_rem;
    logic [PCT_W-1:0]    r_quot;
    logic [STEP_W-1:0]   r_step;
    logic [PCT_W-1:0]    r_load0;
    logic [PCT_W-1:0]    r_load1;
    logic [MP_W-1:0]     r_mprod0;
    logic [MP_W-1:0]     r_mprod1;
    logic                r_out_valid;
    logic [PCT_W-1:0]    r_out_usage;
    logic [PCT_W-1:0]    r_out_core0;
    logic [PCT_W-1:0]    r_out_core1;
    logic                r_out_closed;

    logic [CNT_W-1:0]    ref_ext;
    logic [CNT_W-1:0]    cur_count;
    logic [CNT_W-1:0]    div_d;
    logic                div_ge;
    logic [PCT_W-1:0]    n_quot;
    logic [PCT_W-1:0]    n_load;
    logic                load_done;
    logic [TIME_W-1:0]   elapsed;
    logic                closes;
    logic                item_take;
    logic [SUM_W-1:0]    n_sum0;
    logic [SUM_W-1:0]    n_sum1;
    logic [PCT_W-1:0]    n_smooth0;
    logic [PCT_W-1:0]    n_smooth1;
    logic [RCP_M_W-1:0]  rcp_m;
    logic [POS_W-1:0]    n_pos;

    function automatic logic [PCT_W-1:0] mean_of_two(input logic [PCT_W-1:0] a,
                                                      input logic [PCT_W-1:0] b);
        logic [PCT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PCT_W:1];
    endfunction

    assign ref_ext   = CNT_W'(i_cfg.full_idle_reference);
    assign cur_count = r_core ? r_cnt1 : r_cnt0;
    assign rcp_m     = RCP_M_W'(RCP_M);

    // One quotient bit per cycle, most significant first; the quotient never exceeds 100.
    assign div_d  = ref_ext << r_step;
    assign div_ge = (r_rem >= div_d);
    assign n_quot = r_quot | (div_ge ? (PCT_W'(1) << r_step) : '0);

    always_comb begin
        load_done = 1'b0;
        n_load    = n_quot;
        if (r_state == S_MUL) begin
            if (cur_count > ref_ext) begin
                load_done = 1'b1;
                n_load    = '0;
            end else if (ref_ext == '0) begin
                load_done = 1'b1;
                n_load    = LOAD_FULL;
            end
        end else if (r_state == S_DIV && r_step == '0) begin
            load_done = 1'b1;
            n_load    = LOAD_FULL - n_quot;
        end
    end

    assign elapsed   = i_item.now_ms - r_start;
    assign closes    = (elapsed >= TIME_W'(i_cfg.window_ms));
    assign item_take = (r_state == S_IDLE) && i_item_valid
                    && (!i_item.query || !r_out_valid);
    assign o_item_pop = item_take;

    // Running ring sums: the entry being overwritten leaves, the new load enters.
    assign n_sum0    = r_sum0 - SUM_W'(r_hist0[r_pos]) + SUM_W'(r_load0);
    assign n_sum1    = r_sum1 - SUM_W'(r_hist1[r_pos]) + SUM_W'(r_load1);
    assign n_pos     = (r_pos == POS_W'(SMOOTH_DEPTH - 1)) ? '0 : r_pos + 1'b1;
    assign n_smooth0 = PCT_W'(r_mprod0 >> RCP_S);
    assign n_smooth1 = PCT_W'(r_mprod1 >> RCP_S);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt0       <= '0;
            r_cnt1       <= '0;
            r_start      <= '0;
            r_pos        <= '0;
            r_sum0       <= '0;
            r_sum1       <= '0;
            r_smooth0    <= '0;
            r_smooth1    <= '0;
            r_core       <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < SMOOTH_DEPTH; k++) begin
                r_hist0[k] <= '0;
                r_hist1[k] <= '0;
            end
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (load_done) begin
                if (r_core) begin
                    r_load1 <= n_load;
                end else begin
                    r_load0 <= n_load;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (item_take) begin
                        if (!i_item.query) begin
                            if (i_item.core) begin
                                r_cnt1 <= (r_cnt1 == '1) ? r_cnt1 : r_cnt1 + 1'b1;
                            end else begin
                                r_cnt0 <= (r_cnt0 == '1) ? r_cnt0 : r_cnt0 + 1'b1;
                            end
                        end else if (closes) begin
                            r_now   <= i_item.now_ms;
                            r_core  <= 1'b0;
                            r_state <= S_MUL;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_usage  <= mean_of_two(r_smooth0, r_smooth1);
                            r_out_core0  <= r_smooth0;
                            r_out_core1  <= r_smooth1;
                            r_out_closed <= 1'b0;
                        end
                    end
                end
                S_MUL: begin
                    if (load_done) begin
                        r_core  <= 1'b1;
                        r_state <= r_core ? S_UPDATE : S_MUL;
                    end else begin
                        r_prod  <= PROD_W'(cur_count[REF_W-1:0]) * PROD_W'(LOAD_FULL);
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Adding reference minus one turns the floor quotient into a ceiling.
                    r_rem   <= CNT_W'(r_prod) + ref_ext - CNT_W'(1);
                    r_quot  <= '0;
                    r_step  <= STEP_W'(PCT_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - div_d;
                    end
                    r_quot <= n_quot;
                    if (r_step == '0) begin
                        r_core  <= 1'b1;
                        r_state <= r_core ? S_UPDATE : S_MUL;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_hist0[r_pos] <= r_load0;
                    r_hist1[r_pos] <= r_load1;
                    r_sum0  <= n_sum0;
                    r_sum1  <= n_sum1;
                    r_pos   <= n_pos;
                    r_cnt0  <= '0;
                    r_cnt1  <= '0;
                    r_start <= r_now;
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    // Division by the ring depth as a multiply by its rounded-up reciprocal.
                    r_mprod0 <= MP_W'(r_sum0) * MP_W'(rcp_m);
                    r_mprod1 <= MP_W'(r_sum1) * MP_W'(rcp_m);
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    r_smooth0    <= n_smooth0;
                    r_smooth1    <= n_smooth1;
                    r_out_valid  <= 1'b1;
                    r_out_usage  <= mean_of_two(n_smooth0, n_smooth1);
                    r_out_core0  <= n_smooth0;
                    r_out_core1  <= n_smooth1;
                    r_out_closed <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_usage_percent = r_out_usage;
    assign o_core0_percent = r_out_core0;
    assign o_core1_percent = r_out_core1;
    assign o_window_closed = r_out_closed;

endmodule

`default_nettype wire

>>> rtl/cpu_load_window_monitor.sv
// Top level of the CPU load window monitor: configuration registers, input queue
// and execution unit. Depends on clwm_pkg, clwm_regs, clwm_front and clwm_back.
//
// The monitor counts idle events of two cores and answers each usage query with the
// smoothed load of both cores. Transactions enter a two-entry queue and are executed in
// order by one execution unit, one at a time. A query that closes the window takes, per
// core, at most a multiply, a setup step and the bit-serial divider that forms the
// ceiling of count*100/reference, then an update of the history rings, a scaling of
// the ring sums by the reciprocal of the ring depth and the load of the result. The
// divider is shared by the two cores. A query waits at the head of the queue while an
// earlier result has not been popped, and the transactions behind it wait as well.
// Operation code 3 is accepted and discarded.
`timescale 1ns / 1ps
`default_nettype none

module cpu_load_window_monitor import clwm_pkg::*; #(
    parameter int unsigned SMOOTH_DEPTH = SMOOTH_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        i_operation,
    input  wire logic [TIME_W-1:0] i_now_ms,
    output logic                   empty,
    input  wire logic              pop,
    output logic [PCT_W-1:0]       o_usage_percent,
    output logic [PCT_W-1:0]       o_core0_percent,
    output logic [PCT_W-1:0]       o_core1_percent,
    output logic                   o_window_closed,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  item_pop;

    clwm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_operation  (i_operation),
        .i_now_ms     (i_now_ms),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    clwm_back #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_item_pop      (item_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_usage_percent (o_usage_percent),
        .o_core0_percent (o_core0_percent),
        .o_core1_percent (o_core1_percent),
        .o_window_closed (o_window_closed)
    );

endmodule

`default_nettype wire

>>> bench/cpu_load_window_monitor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for cpu_load_window_monitor. A table of directed transactions runs
// first, then random phases under several register settings. Depends on clwm_pkg and the RTL.

module cpu_load_window_monitor_test import clwm_pkg::*; ();

    localparam int unsigned RING_DEPTH   = SMOOTH_DEPTH_DEF;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RANDOM_ITEMS = 1330;
    localparam int unsigned PHASES       = 8;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef struct packed {
        logic [PCT_W-1:0] usage;
        logic [PCT_W-1:0] core0;
        logic [PCT_W-1:0] core1;
        logic             closed;
    } t_load_report;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now;
        logic              typed;
        t_load_report      report;
    } t_stim_row;

    // Runs with the reset settings: 1855000 idle events per window, 1000 ms window.
    localparam int unsigned N_ROWS = 16;
    localparam t_stim_row STIM_TABLE [N_ROWS] = '{
        '{OP_QUERY,  32'd0,          1'b1, '{7'd0,  7'd0,  7'd0,  1'b0}},
        '{OP_QUERY,  32'd999,        1'b1, '{7'd0,  7'd0,  7'd0,  1'b0}},
        '{OP_UNUSED, 32'hFFFF_FFFF,  1'b0, '0},
        '{OP_QUERY,  32'd1000,       1'b1, '{7'd20, 7'd20, 7'd20, 1'b1}},
        '{OP_IDLE0,  32'hFFFF_FFFF,  1'b0, '0},
        '{OP_IDLE1,  32'd0,          1'b0, '0},
        '{OP_IDLE1,  32'h5555_AAAA,  1'b0, '0},
        '{OP_QUERY,  32'hFFFF_FFFF,  1'b0, '0},
        '{OP_QUERY,  32'd998,        1'b0, '0},
        '{OP_QUERY,  32'd999,        1'b0, '0},
        '{OP_QUERY,  32'd1999,       1'b0, '0},
        '{OP_IDLE0,  32'h0000_0001,  1'b0, '0},
        '{OP_QUERY,  32'd2999,       1'b0, '0},
        '{OP_QUERY,  32'd3999,       1'b0, '0},
        '{OP_QUERY,  32'd3999,       1'b0, '0},
        '{OP_QUERY,  32'hAAAA_5555,  1'b0, '0}
    };

    localparam logic [REF_W-1:0] PHASE_REF [PHASES] = '{
        24'd20, 24'd1, 24'd0, 24'hFF_FFFF, 24'd7, 24'd0, 24'd1855000, 24'd0
    };
    localparam logic [WIN_W-1:0] PHASE_WIN [PHASES] = '{
        16'd5, 16'd1, 16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd1000, 16'd0
    };
    localparam bit PHASE_RANDOM [PHASES] = '{0, 0, 0, 0, 0, 1, 0, 1};

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [1:0]        op_drv;
    logic [TIME_W-1:0] now_drv;
    logic              empty;
    logic              pop;
    logic [PCT_W-1:0]  o_usage_percent;
    logic [PCT_W-1:0]  o_core0_percent;
    logic [PCT_W-1:0]  o_core1_percent;
    logic              o_window_closed;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Mirror of the monitor state.
    logic [REF_W-1:0]  cfg_ref;
    logic [WIN_W-1:0]  cfg_win;
    logic [CNT_W-1:0]  idle_cnt [2];
    logic [TIME_W-1:0] win_begin;
    logic [PCT_W-1:0]  hist [2][RING_DEPTH];
    int unsigned       slot;
    logic [PCT_W-1:0]  smooth [2];

    t_load_report pending_reports [$];
    int unsigned  mismatches;
    int unsigned  reports_checked;
    int unsigned  closures_seen;
    int unsigned  items_sent;
    int unsigned  cycles;
    bit           quiet;

    cpu_load_window_monitor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (op_drv),
        .i_now_ms        (now_drv),
        .empty           (empty),
        .pop             (pop),
        .o_usage_percent (o_usage_percent),
        .o_core0_percent (o_core0_percent),
        .o_core1_percent (o_core1_percent),
        .o_window_closed (o_window_closed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports outstanding.", cycles,
                     pending_reports.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        if (mismatches < 10)
            $display("Mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one accepted transaction to the mirror; returns 1 when it yields a report.
    function automatic bit advance_load_monitor(input logic [1:0] op,
                                                input logic [TIME_W-1:0] now,
                                                output t_load_report rep);
        logic [63:0]       up;
        logic [9:0]        sum;
        logic [TIME_W-1:0] elapsed;
        rep = '0;
        if (op == OP_IDLE0 || op == OP_IDLE1) begin
            // Counters stick at all ones instead of wrapping.
            if (idle_cnt[op[0]] != '1)
                idle_cnt[op[0]] = idle_cnt[op[0]] + 1'b1;
            return 1'b0;
        end
        if (op != OP_QUERY)
            return 1'b0;
        elapsed = now - win_begin;
        if (elapsed >= TIME_W'(cfg_win)) begin
            for (int c = 0; c < 2; c++) begin
                if (64'(idle_cnt[c]) > 64'(cfg_ref)) begin
                    hist[c][slot] = '0;
                end else if (cfg_ref == '0) begin
                    hist[c][slot] = LOAD_FULL;
                end else begin
                    up = (64'(idle_cnt[c]) * 64'd100 + 64'(cfg_ref) - 64'd1) / 64'(cfg_ref);
                    if (up > 64'd100)
                        up = 64'd100;
                    hist[c][slot] = PCT_W'(64'd100 - up);
                end
                idle_cnt[c] = '0;
                sum = '0;
                for (int k = 0; k < RING_DEPTH; k++)
                    sum = sum + 10'(hist[c][k]);
                smooth[c] = PCT_W'(sum / RING_DEPTH);
            end
            slot = (slot + 1) % RING_DEPTH;
            win_begin = now;
            rep.closed = 1'b1;
        end
        rep.usage = PCT_W'((8'(smooth[0]) + 8'(smooth[1])) / 2);
        rep.core0 = smooth[0];
        rep.core1 = smooth[1];
        return 1'b1;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] now,
                             input logic typed, input t_load_report typed_report);
        int unsigned  gap;
        t_load_report rep;
        gap = (!quiet && $urandom_range(0, 6) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        op_drv  <= op;
        now_drv <= now;
        do @(posedge i_clk); while (full);
        if (op != OP_UNUSED)
            items_sent++;
        if (advance_load_monitor(op, now, rep))
            pending_reports.push_back(typed ? typed_report : rep);
    endtask

    // Stops input and lets queued idle events finish before registers change.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] back;
        logic [APB_DW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_REF) begin
            cfg_ref = value[REF_W-1:0];
            want    = APB_DW'(cfg_ref);
        end else begin
            cfg_win = value[WIN_W-1:0];
            want    = APB_DW'(cfg_win);
        end
        // Read the register straight back.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back !== want)
            note_mismatch($sformatf("register %0d read %h, expected %h", idx, back, want));
    endtask

    initial begin : result_checker
        int unsigned  stall_left;
        t_load_report got;
        t_load_report want;
        stall_left = 0;
        pop <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got = '{o_usage_percent, o_core0_percent, o_core1_percent, o_window_closed};
                if (pending_reports.size() == 0) begin
                    note_mismatch($sformatf("unexpected report usage=%0d c0=%0d c1=%0d closed=%0b",
                                            got.usage, got.core0, got.core1, got.closed));
                end else begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    if (got.closed)
                        closures_seen++;
                    if (got.usage !== want.usage || got.core0 !== want.core0 ||
                        got.core1 !== want.core1 || got.closed !== want.closed)
                        note_mismatch($sformatf(
                            "usage/c0/c1/closed expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                            want.usage, want.core0, want.core1, want.closed,
                            got.usage, got.core0, got.core1, got.closed));
                end
            end
            if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned       phase_end;
        int unsigned       cap;
        int unsigned       n0;
        int unsigned       n1;
        logic [REF_W-1:0]  new_ref;
        logic [WIN_W-1:0]  new_win;
        logic [1:0]        op;
        logic [TIME_W-1:0] stamp;

        i_rst_n <= 1'b0;
        push    <= 1'b0;
        op_drv  <= OP_IDLE0;
        now_drv <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        cycles          = 0;
        mismatches      = 0;
        reports_checked = 0;
        closures_seen   = 0;
        items_sent      = 0;
        quiet           = 1'b0;
        cfg_ref   = REF_RESET;
        cfg_win   = WINDOW_RESET;
        win_begin = '0;
        slot      = 0;
        for (int c = 0; c < 2; c++) begin
            idle_cnt[c] = '0;
            smooth[c]   = '0;
            for (int k = 0; k < RING_DEPTH; k++)
                hist[c][k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_item(STIM_TABLE[r].op, STIM_TABLE[r].now, STIM_TABLE[r].typed,
                      STIM_TABLE[r].report);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_until_drained();
            new_ref = PHASE_RANDOM[ph] ? REF_W'($urandom_range(1, 60)) : PHASE_REF[ph];
            new_win = PHASE_RANDOM[ph] ? WIN_W'($urandom_range(1, 20)) : PHASE_WIN[ph];
            // Upper bits carry noise that the registers must drop.
            write_reg(REG_REF, {8'($urandom), new_ref});
            write_reg(REG_WINDOW, {16'($urandom), new_win});
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                quiet = (items_sent > N_ROWS + RANDOM_ITEMS * 17 / 20);
                if ($urandom_range(0, 9) == 0) begin
                    op = 2'($urandom_range(0, 3));
                    send_item(op, $urandom, 1'b0, '0);
                end else begin
                    // One window: idle events on both cores, sometimes a query inside the window, then a closing query.
                    cap = (cfg_ref < 40) ? cfg_ref + 2 : 40;
                    n0  = $urandom_range(0, cap);
                    n1  = $urandom_range(0, cap);
                    while (n0 + n1 > 0) begin
                        if (n1 == 0 || (n0 > 0 && $urandom_range(0, 1) == 1)) begin
                            send_item(OP_IDLE0, $urandom, 1'b0, '0);
                            n0--;
                        end else begin
                            send_item(OP_IDLE1, $urandom, 1'b0, '0);
                            n1--;
                        end
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        stamp = win_begin + $urandom_range(0, (cfg_win > 0) ? cfg_win - 1 : 0);
                        send_item(OP_QUERY, stamp, 1'b0, '0);
                    end
                    stamp = win_begin + cfg_win + $urandom_range(0, 2 * cfg_win);
                    send_item(OP_QUERY, stamp, 1'b0, '0);
                end
            end
        end

        wait_until_drained();
        $display("Sent %0d transactions over %0d register settings; checked %0d reports,",
                 items_sent, PHASES + 1, reports_checked);
        $display("%0d of which closed a load window.", closures_seen);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d reports never arrived.", mismatches,
                     pending_reports.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
